>>> rtl/core/kdar_pkg.sv
// ---------------------------------------------------------------------------
// kdar_pkg: shared types and constants of the key debouncer
// Register indexes, reset values, state and configuration records, and the
// per-level byte selector used by the step logic.
// ---------------------------------------------------------------------------
package kdar_pkg;

    localparam int KEY_W     = 8;
    localparam int CONF_W    = 4;
    localparam int LEVEL_W   = 3;
    localparam int REPS_W    = 8;
    localparam int TIMER_W   = 9;
    localparam int TABLE_W   = 48;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_KEY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAYS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELLS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEEDS       = 3'd4;

    // Reset values of the configuration registers
    localparam logic [KEY_W-1:0]   RESET_IDLE_KEY = 8'd0;
    localparam logic [CONF_W-1:0]  RESET_LIMIT    = 4'd3;
    localparam logic [TABLE_W-1:0] RESET_DELAYS   = 48'h010101030C19;
    localparam logic [TABLE_W-1:0] RESET_DWELLS   = 48'h018E47180301;
    localparam logic [TABLE_W-1:0] RESET_SPEEDS   = 48'h1E0A02010101;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL  = 3'd5;
    localparam logic [LEVEL_W-1:0] LONG_LEVEL = 3'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   idle_key;
        logic [CONF_W-1:0]  settle_limit;
        logic [TABLE_W-1:0] delays;
        logic [TABLE_W-1:0] dwells;
        logic [TABLE_W-1:0] speeds;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]   held_key;
        logic [CONF_W-1:0]  confidence;
        logic [LEVEL_W-1:0] hold_level;
        logic [REPS_W-1:0]  repeats;
        logic [TIMER_W-1:0] timer;
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             fresh;
        logic [7:0]       speed;
        logic             long_press;
    } event_t;

    // Byte of a six-byte table for a hold level; levels above the top read the top byte.
    function automatic logic [7:0] byte_of(input logic [TABLE_W-1:0] word,
                                           input logic [LEVEL_W-1:0] level);
        logic [7:0] result;
        case (level)
            3'd0:    result = word[7:0];
            3'd1:    result = word[15:8];
            3'd2:    result = word[23:16];
            3'd3:    result = word[31:24];
            3'd4:    result = word[39:32];
            default: result = word[47:40];
        endcase
        return result;
    endfunction

endpackage

>>> rtl/core/kdar_step.sv
// ---------------------------------------------------------------------------
// kdar_step: one sample tick of the debouncer
// Works out the next debounce and repeat state and any event for one sample.
// ---------------------------------------------------------------------------
module kdar_step (
    input  kdar_pkg::cfg_t                  cfg,
    input  kdar_pkg::state_t                state,
    input  logic [kdar_pkg::KEY_W-1:0]      key,
    output kdar_pkg::state_t                state_next,
    output logic                            fire,
    output kdar_pkg::event_t                evt
);

    logic                               differ;
    logic [kdar_pkg::CONF_W:0]          conf_t;
    logic [kdar_pkg::TIMER_W-1:0]       timer_t;
    logic [kdar_pkg::REPS_W-1:0]        reps_t;
    logic [kdar_pkg::LEVEL_W-1:0]       level_t;

    always_comb
    begin
        differ     = (key != state.held_key);
        state_next = state;
        fire       = 1'b0;
        conf_t     = {1'b0, state.confidence};
        timer_t    = state.timer;
        reps_t     = state.repeats;
        level_t    = state.hold_level;

        if (differ && (state.confidence == '0))
        begin
            // Debounced change: latch the new key and restart the hold sequence.
            state_next.held_key   = key;
            state_next.hold_level = '0;
            state_next.repeats    = '0;
            state_next.timer      = '0;
            level_t               = '0;
            fire                  = 1'b1;
        end
        else
        begin
            if (differ)
                conf_t = conf_t - 1'b1;
            else
                conf_t = conf_t + 1'b1;

            if (conf_t > {1'b0, cfg.settle_limit})
            begin
                conf_t  = {1'b0, cfg.settle_limit};
                timer_t = timer_t + 1'b1;
            end
            state_next.confidence = conf_t[kdar_pkg::CONF_W-1:0];

            if (timer_t > {1'b0, kdar_pkg::byte_of(cfg.delays, state.hold_level)})
            begin
                timer_t = '0;
                fire    = 1'b1;
                if ((state.hold_level < kdar_pkg::TOP_LEVEL) && (key != cfg.idle_key))
                begin
                    reps_t = reps_t + 1'b1;
                    if (reps_t >= kdar_pkg::byte_of(cfg.dwells, state.hold_level))
                    begin
                        level_t = level_t + 1'b1;
                        reps_t  = '0;
                    end
                end
            end
            state_next.timer      = timer_t;
            state_next.repeats    = reps_t;
            state_next.hold_level = level_t;
        end

        evt.key        = key;
        evt.fresh      = differ && (state.confidence == '0);
        evt.speed      = kdar_pkg::byte_of(cfg.speeds, level_t);
        evt.long_press = (level_t > kdar_pkg::LONG_LEVEL);
    end

endmodule

>>> rtl/core/key_debounce_autorepeat.sv
// ---------------------------------------------------------------------------
// key_debounce_autorepeat: keypad debouncer with accelerating auto-repeat
// Filters raw key codes and reports new presses and repeats of a held key.
// ---------------------------------------------------------------------------
// Usage. Each request on the sample channel (sample_valid, sample_stall,
// sampled_key) is one sample tick of the raw key code. A request on the event
// channel (event_valid, event_stall and the four event fields) reports either
// a debounced key change or an auto-repeat of the held key, with the speed
// factor of the hold level and a long-press flag. A tick yields zero or one
// event.
// Flow: a sample is captured in an input register and worked through from
// there into the event register, which presents its event. One sample is
// taken every cycle while the event side keeps up; the single pass from the
// input register to the event register, which also updates the debounce
// state, sets that rate.
// Stalls: an event waits in the output register while event_stall is high.
// One further sample is held in the input register; after that sample_stall
// rises until the waiting event is taken.
// Reset: the debounce state clears, the held key becomes the idle code and
// the configuration registers take their defaults. Registers are written
// through cfg_valid/cfg_index/cfg_data, always ready; write them while idle.
// ---------------------------------------------------------------------------
module key_debounce_autorepeat (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [kdar_pkg::KEY_W-1:0]          sampled_key,
    // event channel
    output logic                                event_valid,
    input  logic                                event_stall,
    output logic [kdar_pkg::KEY_W-1:0]          event_key,
    output logic                                is_new_press,
    output logic [7:0]                          speed_factor,
    output logic                                long_press,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kdar_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kdar_pkg::TABLE_W-1:0]        cfg_data
);

    kdar_pkg::cfg_t                     cfg_reg;
    kdar_pkg::state_t                   state_reg;
    kdar_pkg::state_t                   state_next;
    logic                               in_valid_reg;
    logic [kdar_pkg::KEY_W-1:0]         in_key_reg;
    logic                               out_valid_reg;
    kdar_pkg::event_t                   out_reg;
    kdar_pkg::event_t                   evt;
    logic                               fire;
    logic                               advance;
    logic                               take_sample;

    // The held sample is worked through once the output register can take
    // its event; a sample that yields no event waits for the same condition.
    assign advance      = in_valid_reg && (!out_valid_reg || !event_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign take_sample  = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;

    kdar_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .key        (in_key_reg),
        .state_next (state_next),
        .fire       (fire),
        .evt        (evt)
    );

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_key     <= kdar_pkg::RESET_IDLE_KEY;
            cfg_reg.settle_limit <= kdar_pkg::RESET_LIMIT;
            cfg_reg.delays       <= kdar_pkg::RESET_DELAYS;
            cfg_reg.dwells       <= kdar_pkg::RESET_DWELLS;
            cfg_reg.speeds       <= kdar_pkg::RESET_SPEEDS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kdar_pkg::REG_IDLE_KEY:     cfg_reg.idle_key     <= cfg_data[kdar_pkg::KEY_W-1:0];
                kdar_pkg::REG_SETTLE_LIMIT: cfg_reg.settle_limit <= cfg_data[kdar_pkg::CONF_W-1:0];
                kdar_pkg::REG_DELAYS:       cfg_reg.delays       <= cfg_data;
                kdar_pkg::REG_DWELLS:       cfg_reg.dwells       <= cfg_data;
                kdar_pkg::REG_SPEEDS:       cfg_reg.speeds       <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Debounce state: the held key starts as the default idle code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.held_key   <= kdar_pkg::RESET_IDLE_KEY;
            state_reg.confidence <= '0;
            state_reg.hold_level <= '0;
            state_reg.repeats    <= '0;
            state_reg.timer      <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take_sample)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
            in_key_reg <= sampled_key;
    end

    // Event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire;
        else if (!event_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire)
            out_reg <= evt;
    end

    assign event_valid  = out_valid_reg;
    assign event_key    = out_reg.key;
    assign is_new_press = out_reg.fresh;
    assign speed_factor = out_reg.speed;
    assign long_press   = out_reg.long_press;

endmodule
